// File: rtl/nibble_command_sensor_slave_macros.svh
// ----------------------------------------------------------------------------
// nibble_command_sensor_slave_macros.svh
// Assertion macros shared by the RTL files. Each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_COMMAND_SENSOR_SLAVE_MACROS_SVH
`define NIBBLE_COMMAND_SENSOR_SLAVE_MACROS_SVH

// same-cycle implication
`define NCS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ncs assertion failed");

// next-cycle implication
`define NCS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ncs assertion failed");

`endif

// File: rtl/ncs_pkg.sv
// ----------------------------------------------------------------------------
// ncs_pkg
// Types and constants of the nibble command / sensor slave.
// ----------------------------------------------------------------------------
package ncs_pkg;

	localparam int SAMPLE_W        = 10;  // width of the sample_value port
	localparam int SAMPLE_MAX_BITS = 12;  // widest stored sample
	localparam int THR_W           = 10;
	localparam int NIB_W           = 4;
	localparam int RUN_MAX         = 4;   // most words one item produces
	localparam int RUN_IDX_W       = 2;

	localparam logic [THR_W-1:0] HIGH_RESET = 10'd520;
	localparam logic [THR_W-1:0] LOW_RESET  = 10'd360;

	localparam logic [NIB_W-1:0] REPLY_ACK = 4'hE;
	localparam logic [NIB_W-1:0] REPLY_OFF = 4'hC;

	typedef enum logic [NIB_W-1:0] {
		CMD_RESET  = 4'h0,
		CMD_PING   = 4'h1,
		CMD_GET    = 4'h2,
		CMD_TOGGLE = 4'h3,
		CMD_LIGHT  = 4'hD
	} cmd_t;

	typedef enum logic {
		REG_HIGH = 1'b0,
		REG_LOW  = 1'b1
	} reg_idx_t;

	typedef enum logic {
		OP_COMMAND = 1'b0,
		OP_SAMPLE  = 1'b1
	} op_t;

	// one item's worth of result words; word 0 goes out first
	typedef struct packed {
		logic [RUN_MAX-1:0][NIB_W-1:0] nibs;
		logic [RUN_IDX_W-1:0]          last_idx;
		logic                          reply_valid;
		logic                          led;
	} run_t;

endpackage

// File: rtl/nibble_command_sensor_slave.sv
// ----------------------------------------------------------------------------
// nibble_command_sensor_slave
// Command / sensor slave: host command nibbles and converter samples in,
// reply nibbles and LED level out.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid / item_stall): opcode selects a command nibble
//   (command_code) or a converter sample (sample_value). Result channel
//   (result_valid / result_stall) carries reply_nibble, reply_valid,
//   last_of_run and led_level; last_of_run marks the final word of an item.
//   Configuration: cfg_we writes cfg_data to high (index 0) or low (index 1)
//   threshold; write only while the block is idle.
//   Path: an accepted item is registered in the input register, then loaded
//   into the result register, which drives its first word.
//   Throughput: one item per cycle while result_stall is low, except GET,
//   which holds the result register for its four words; the result register,
//   which sends one word per cycle when not stalled, sets this rate.
//   Reset: thresholds return to 520 / 360, stored sample and latch clear,
//   sampling is enabled, LED state off (led_level is not reset), both registers empty.
//   When the receiver stalls, the current word holds; one further item waits
//   in the input register and item_stall rises until the run is taken.
// ----------------------------------------------------------------------------
module nibble_command_sensor_slave #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          opcode,
	input  logic [ncs_pkg::NIB_W-1:0]     command_code,
	input  logic [ncs_pkg::SAMPLE_W-1:0]  sample_value,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [ncs_pkg::THR_W-1:0]     cfg_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [ncs_pkg::NIB_W-1:0]     reply_nibble,
	output logic                          reply_valid,
	output logic                          last_of_run,
	output logic                          led_level
);

	logic          run_ready;
	logic          run_load;
	ncs_pkg::run_t run;

	ncs_exec #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_exec (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.command_code (command_code),
		.sample_value (sample_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.run_ready    (run_ready),
		.run_load     (run_load),
		.run          (run)
	);

	ncs_reply u_reply (
		.clk          (clk),
		.arst_n       (arst_n),
		.run_load     (run_load),
		.run          (run),
		.run_ready    (run_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.reply_nibble (reply_nibble),
		.reply_valid  (reply_valid),
		.last_of_run  (last_of_run),
		.led_level    (led_level)
	);

endmodule

// File: rtl/ncs_exec.sv
// ----------------------------------------------------------------------------
// ncs_exec
// Input register, configuration and state registers, and the step logic that
// turns one registered item into a run of result words.
// ----------------------------------------------------------------------------
module ncs_exec #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic                           opcode,
	input  logic [ncs_pkg::NIB_W-1:0]      command_code,
	input  logic [ncs_pkg::SAMPLE_W-1:0]   sample_value,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [ncs_pkg::THR_W-1:0]      cfg_data,
	input  logic                           run_ready,
	output logic                           run_load,
	output ncs_pkg::run_t                  run
);

	`include "nibble_command_sensor_slave_macros.svh"

	localparam int CMP_W = (SAMPLE_BITS > ncs_pkg::THR_W) ? SAMPLE_BITS : ncs_pkg::THR_W;

	logic                          valid_s1;
	logic                          opcode_s1;
	logic [ncs_pkg::NIB_W-1:0]     cmd_s1;
	logic [SAMPLE_BITS-1:0]        sample_s1;
	logic [SAMPLE_BITS-1:0]        sample_in;

	logic [ncs_pkg::THR_W-1:0]     high_q, low_q;
	logic [SAMPLE_BITS-1:0]        stored_q, stored_d;
	logic                          latch_q, latch_d;
	logic                          en_q, en_d;
	logic                          led_q, led_d;

	logic [ncs_pkg::SAMPLE_MAX_BITS-1:0] stored_ext;
	logic [CMP_W-1:0]                    samp_cmp, high_cmp, low_cmp;
	logic                                item_acc;

	generate
		if (SAMPLE_BITS <= ncs_pkg::SAMPLE_W) begin : g_trunc
			assign sample_in = sample_value[SAMPLE_BITS-1:0];
		end else begin : g_ext
			assign sample_in = SAMPLE_BITS'(sample_value);
		end
	endgenerate

	assign run_load   = valid_s1 && run_ready;
	assign item_stall = valid_s1 && !run_ready;
	assign item_acc   = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_acc) begin
			valid_s1 <= 1'b1;
		end else if (run_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			opcode_s1 <= opcode;
			cmd_s1    <= command_code;
			sample_s1 <= sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= ncs_pkg::HIGH_RESET;
			low_q  <= ncs_pkg::LOW_RESET;
		end else if (cfg_we) begin
			case (ncs_pkg::reg_idx_t'(cfg_index))
				ncs_pkg::REG_HIGH: high_q <= cfg_data;
				ncs_pkg::REG_LOW:  low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
			latch_q  <= 1'b0;
			en_q     <= 1'b1;
			led_q    <= 1'b0;
		end else if (run_load) begin
			stored_q <= stored_d;
			latch_q  <= latch_d;
			en_q     <= en_d;
			led_q    <= led_d;
		end
	end

	assign stored_ext = ncs_pkg::SAMPLE_MAX_BITS'(stored_q);
	assign samp_cmp   = CMP_W'(sample_s1);
	assign high_cmp   = CMP_W'(high_q);
	assign low_cmp    = CMP_W'(low_q);

	always_comb begin
		stored_d         = stored_q;
		latch_d          = latch_q;
		en_d             = en_q;
		led_d            = led_q;
		run.nibs         = '0;
		run.last_idx     = '0;
		run.reply_valid  = 1'b1;
		if (ncs_pkg::op_t'(opcode_s1) == ncs_pkg::OP_SAMPLE) begin
			run.reply_valid = 1'b0;
			if (en_q) begin
				stored_d = sample_s1;
				if (samp_cmp > high_cmp) begin
					led_d = 1'b1;
				end else if (!latch_q && samp_cmp < low_cmp) begin
					led_d = 1'b0;
				end else if (latch_q) begin
					led_d = 1'b1;
				end
			end
		end else begin
			case (ncs_pkg::cmd_t'(cmd_s1))
				ncs_pkg::CMD_GET: begin
					run.nibs[0]  = stored_ext[11:8];
					run.nibs[1]  = stored_ext[7:4];
					run.nibs[2]  = stored_ext[3:0];
					run.nibs[3]  = ncs_pkg::REPLY_ACK;
					run.last_idx = ncs_pkg::RUN_IDX_W'(ncs_pkg::RUN_MAX - 1);
				end
				ncs_pkg::CMD_LIGHT: begin
					latch_d = !latch_q;
					if (latch_q) begin
						run.nibs[0] = ncs_pkg::REPLY_OFF;
					end else begin
						led_d       = 1'b1;
						run.nibs[0] = ncs_pkg::REPLY_ACK;
					end
				end
				ncs_pkg::CMD_RESET: begin
					stored_d    = '0;
					run.nibs[0] = ncs_pkg::REPLY_ACK;
				end
				ncs_pkg::CMD_PING: begin
					run.nibs[0] = ncs_pkg::REPLY_ACK;
				end
				ncs_pkg::CMD_TOGGLE: begin
					en_d        = !en_q;
					run.nibs[0] = en_q ? ncs_pkg::REPLY_OFF : ncs_pkg::REPLY_ACK;
				end
				default: begin
					run.nibs[0] = cmd_s1;
				end
			endcase
		end
		run.led = led_d;
	end

	`NCS_ASSERT_IMP(a_stall_needs_item, item_stall, valid_s1)
	`NCS_ASSERT_NXT(a_held_item_stays, item_stall, valid_s1 && $stable(cmd_s1))

endmodule

// File: rtl/ncs_reply.sv
// ----------------------------------------------------------------------------
// ncs_reply
// Result register: holds one run and sends its words one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ncs_reply (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          run_load,
	input  ncs_pkg::run_t                 run,
	output logic                          run_ready,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [ncs_pkg::NIB_W-1:0]     reply_nibble,
	output logic                          reply_valid,
	output logic                          last_of_run,
	output logic                          led_level
);

	`include "nibble_command_sensor_slave_macros.svh"

	logic                                           busy_q;
	logic [ncs_pkg::RUN_MAX-1:0][ncs_pkg::NIB_W-1:0] nib_q;
	logic [ncs_pkg::RUN_IDX_W-1:0]                  cnt_q;
	logic                                           rv_q;
	logic                                           led_q;
	logic                                           out_acc;

	assign out_acc      = busy_q && !result_stall;
	assign last_of_run  = (cnt_q == '0);
	assign run_ready    = !busy_q || (out_acc && last_of_run);
	assign result_valid = busy_q;
	assign reply_nibble = nib_q[0];
	assign reply_valid  = rv_q;
	assign led_level    = led_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (run_load) begin
			busy_q <= 1'b1;
		end else if (out_acc && last_of_run) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run_load) begin
			nib_q <= run.nibs;
			cnt_q <= run.last_idx;
			rv_q  <= run.reply_valid;
			led_q <= run.led;
		end else if (out_acc && !last_of_run) begin
			// move the next word to the front
			for (int i = 0; i < ncs_pkg::RUN_MAX - 1; i++) begin
				nib_q[i] <= nib_q[i+1];
			end
			nib_q[ncs_pkg::RUN_MAX-1] <= '0;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	`NCS_ASSERT_IMP(a_load_when_free, run_load, run_ready)
	`NCS_ASSERT_IMP(a_sample_single, result_valid && !reply_valid, last_of_run)
	`NCS_ASSERT_NXT(a_run_continues, out_acc && !last_of_run, result_valid && $stable(reply_valid))

endmodule

// File: sim/ncs_reply_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ncs_reply_checker
// Watches the item, result and configuration ports of the command / sensor
// slave, predicts the reply words of every accepted item and compares each
// accepted result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ncs_reply_checker #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_stall,
	input  logic                         opcode,
	input  logic [ncs_pkg::NIB_W-1:0]    command_code,
	input  logic [ncs_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [ncs_pkg::THR_W-1:0]    cfg_data,
	input  logic                         result_valid,
	input  logic                         result_stall,
	input  logic [ncs_pkg::NIB_W-1:0]    reply_nibble,
	input  logic                         reply_valid,
	input  logic                         last_of_run,
	input  logic                         led_level,
	output int                           mismatch_count,
	output int                           words_outstanding
);

	typedef struct packed {
		logic [ncs_pkg::NIB_W-1:0] nib;
		logic                      rvalid;
		logic                      last;
		logic                      led;
	} reply_word_t;

	localparam int KEEP_MASK = (1 << SAMPLE_BITS) - 1;
	localparam int TOP_MASK  = (1 << (SAMPLE_BITS - 8)) - 1;

	logic [ncs_pkg::THR_W-1:0]    high_thr;
	logic [ncs_pkg::THR_W-1:0]    low_thr;
	logic [ncs_pkg::SAMPLE_W-1:0] stored;
	logic                         latch;
	logic                         sampling_on;
	logic                         led;
	reply_word_t                  expected_words[$];
	reply_word_t                  oldest;
	int                           errs;

	task automatic predict_replies(input logic op, input logic [ncs_pkg::NIB_W-1:0] code,
		input logic [ncs_pkg::SAMPLE_W-1:0] raw);
		logic [ncs_pkg::NIB_W-1:0]    nibs[$];
		logic [ncs_pkg::SAMPLE_W-1:0] s;
		s = ncs_pkg::SAMPLE_W'(raw & KEEP_MASK);
		if (ncs_pkg::op_t'(op) == ncs_pkg::OP_SAMPLE) begin
			if (sampling_on) begin
				stored = s;
				if (s > high_thr)
					led = 1'b1;
				else if (!latch && s < low_thr)
					led = 1'b0;
				else if (latch)
					led = 1'b1;
			end
			expected_words.push_back('{nib: '0, rvalid: 1'b0, last: 1'b1, led: led});
		end else begin
			case (ncs_pkg::cmd_t'(code))
			ncs_pkg::CMD_GET: begin
				nibs.push_back(ncs_pkg::NIB_W'((stored >> 8) & TOP_MASK));
				nibs.push_back(ncs_pkg::NIB_W'(stored >> 4));
				nibs.push_back(ncs_pkg::NIB_W'(stored));
				nibs.push_back(ncs_pkg::REPLY_ACK);
			end
			ncs_pkg::CMD_LIGHT: begin
				// clearing the latch leaves the LED where it is
				if (latch) begin
					latch = 1'b0;
					nibs.push_back(ncs_pkg::REPLY_OFF);
				end else begin
					latch = 1'b1;
					led   = 1'b1;
					nibs.push_back(ncs_pkg::REPLY_ACK);
				end
			end
			ncs_pkg::CMD_RESET: begin
				stored = '0;
				nibs.push_back(ncs_pkg::REPLY_ACK);
			end
			ncs_pkg::CMD_PING: nibs.push_back(ncs_pkg::REPLY_ACK);
			ncs_pkg::CMD_TOGGLE: begin
				sampling_on = !sampling_on;
				nibs.push_back(sampling_on ? ncs_pkg::REPLY_ACK : ncs_pkg::REPLY_OFF);
			end
			default: nibs.push_back(code);
			endcase
			foreach (nibs[i])
				expected_words.push_back('{nib: nibs[i], rvalid: 1'b1,
					last: (i == nibs.size() - 1), led: led});
		end
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr    = ncs_pkg::HIGH_RESET;
			low_thr     = ncs_pkg::LOW_RESET;
			stored      = '0;
			latch       = 1'b0;
			sampling_on = 1'b1;
			led         = 1'b0;
			errs        = 0;
			expected_words.delete();
			mismatch_count    <= 0;
			words_outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (ncs_pkg::reg_idx_t'(cfg_index) == ncs_pkg::REG_HIGH)
					high_thr = cfg_data;
				else
					low_thr = cfg_data;
			end
			// an item's words pass the input and result registers first, so check before predicting
			if (result_valid && !result_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual nibble %0h valid %0b",
						$time, reply_nibble, reply_valid);
					errs++;
				end else begin
					oldest = expected_words.pop_front();
					check_field("reply_nibble", oldest.nib, reply_nibble);
					check_field("reply_valid", oldest.rvalid, reply_valid);
					check_field("last_of_run", oldest.last, last_of_run);
					check_field("led_level", oldest.led, led_level);
				end
			end
			if (item_valid && !item_stall)
				predict_replies(opcode, command_code, sample_value);
			mismatch_count    <= errs;
			words_outstanding <= expected_words.size();
		end
	end

endmodule

// File: sim/tb_nibble_command_sensor_slave.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nibble_command_sensor_slave
// Drives commands and converter samples into the command / sensor slave with
// random gaps and random result stalls, across several threshold settings;
// a checker beside the block predicts and compares every reply word.
// ----------------------------------------------------------------------------
module tb_nibble_command_sensor_slave;

	localparam int SAMPLE_BITS = 10;
	localparam int ITEMS_PER_PHASE = 36;

	logic                         clk;
	logic                         arst_n;
	logic                         item_valid;
	logic                         item_stall;
	logic                         opcode;
	logic [ncs_pkg::NIB_W-1:0]    command_code;
	logic [ncs_pkg::SAMPLE_W-1:0] sample_value;
	logic                         cfg_we;
	logic                         cfg_index;
	logic [ncs_pkg::THR_W-1:0]    cfg_data;
	logic                         result_valid;
	logic                         result_stall;
	logic [ncs_pkg::NIB_W-1:0]    reply_nibble;
	logic                         reply_valid;
	logic                         last_of_run;
	logic                         led_level;
	int                           mismatch_count;
	int                           words_outstanding;
	bit                           calm;
	logic [ncs_pkg::THR_W-1:0]    hi_set;
	logic [ncs_pkg::THR_W-1:0]    lo_set;

	nibble_command_sensor_slave #(.SAMPLE_BITS(SAMPLE_BITS)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.opcode       (opcode),
		.command_code (command_code),
		.sample_value (sample_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.reply_nibble (reply_nibble),
		.reply_valid  (reply_valid),
		.last_of_run  (last_of_run),
		.led_level    (led_level)
	);

	ncs_reply_checker #(.SAMPLE_BITS(SAMPLE_BITS)) i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.opcode            (opcode),
		.command_code      (command_code),
		.sample_value      (sample_value),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.reply_nibble      (reply_nibble),
		.reply_valid       (reply_valid),
		.last_of_run       (last_of_run),
		.led_level         (led_level),
		.mismatch_count    (mismatch_count),
		.words_outstanding (words_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL nibble_command_sensor_slave");
		$finish;
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	// result side: a fresh stall length for every word
	initial begin
		int n;
		result_stall <= 1'b0;
		@(posedge clk);
		forever begin
			n = draw_wait();
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	// returns at the edge that accepts the item; valid stays high
	task automatic send_item(input ncs_pkg::op_t op, input logic [ncs_pkg::NIB_W-1:0] code,
		input logic [ncs_pkg::SAMPLE_W-1:0] smp);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid   <= 1'b1;
		opcode       <= op;
		command_code <= code;
		sample_value <= smp;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic write_thresholds(input logic [ncs_pkg::THR_W-1:0] hi,
		input logic [ncs_pkg::THR_W-1:0] lo);
		cfg_we    <= 1'b1;
		cfg_index <= ncs_pkg::REG_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= ncs_pkg::REG_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_we <= 1'b0;
		hi_set = hi;
		lo_set = lo;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (words_outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [ncs_pkg::SAMPLE_W-1:0] near(input logic [ncs_pkg::THR_W-1:0] thr);
		int v;
		v = int'(thr) + $urandom_range(0, 4) - 2;
		if (v < 0) v = 0;
		if (v > 1023) v = 1023;
		return ncs_pkg::SAMPLE_W'(v);
	endfunction

	task automatic send_random(input int count);
		int r;
		logic [ncs_pkg::SAMPLE_W-1:0] smp;
		logic [ncs_pkg::NIB_W-1:0]    code;
		for (int i = 0; i < count; i++) begin
			r    = $urandom_range(0, 99);
			code = ncs_pkg::NIB_W'($urandom_range(0, 15));
			smp  = ncs_pkg::SAMPLE_W'($urandom_range(0, 1023));
			if (r < 50) begin
				// bias samples toward the thresholds to exercise hysteresis
				case ($urandom_range(0, 3))
				0: smp = near(hi_set);
				1: smp = near(lo_set);
				default: ;
				endcase
				send_item(ncs_pkg::OP_SAMPLE, code, smp);
			end else if (r < 62) send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_GET, smp);
			else if (r < 71) send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_LIGHT, smp);
			else if (r < 76) send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_RESET, smp);
			else if (r < 81) send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_PING, smp);
			else if (r < 84) send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_TOGGLE, smp);
			else send_item(ncs_pkg::OP_COMMAND, code, smp);
		end
	endtask

	initial begin
		logic [ncs_pkg::THR_W-1:0] his[6];
		logic [ncs_pkg::THR_W-1:0] los[6];
		his = '{10'd0, 10'd1023, 10'd1023, 10'd0, 10'd600, 10'd0};
		los = '{10'd0, 10'd1023, 10'd0, 10'd1023, 10'd200, 10'd0};
		arst_n       = 1'b0;
		calm         = 1'b0;
		hi_set       = ncs_pkg::HIGH_RESET;
		lo_set       = ncs_pkg::LOW_RESET;
		item_valid   <= 1'b0;
		opcode       <= ncs_pkg::OP_COMMAND;
		command_code <= '0;
		sample_value <= '0;
		cfg_we       <= 1'b0;
		cfg_index    <= ncs_pkg::REG_HIGH;
		cfg_data     <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset thresholds 520 / 360
		send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_GET, 10'h3FF);
		send_item(ncs_pkg::OP_SAMPLE, 4'hF, 10'd1023);
		send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_GET, 10'h000);
		send_item(ncs_pkg::OP_SAMPLE, 4'h0, 10'd0);
		send_item(ncs_pkg::OP_SAMPLE, 4'h5, 10'd520);
		send_item(ncs_pkg::OP_SAMPLE, 4'hA, 10'd521);
		send_item(ncs_pkg::OP_SAMPLE, 4'h0, 10'd360);
		send_item(ncs_pkg::OP_SAMPLE, 4'h0, 10'd359);
		send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_LIGHT, 10'h2AA);
		send_item(ncs_pkg::OP_SAMPLE, 4'h0, 10'd0);
		send_item(ncs_pkg::OP_SAMPLE, 4'h0, 10'd400);
		send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_LIGHT, 10'h155);
		send_item(ncs_pkg::OP_SAMPLE, 4'h0, 10'h2AA);
		send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_GET, 10'h000);
		send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_RESET, 10'h000);
		send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_GET, 10'h000);
		send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_TOGGLE, 10'h000);
		send_item(ncs_pkg::OP_SAMPLE, 4'h0, 10'd1023);
		send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_GET, 10'h000);
		send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_TOGGLE, 10'h000);
		send_item(ncs_pkg::OP_COMMAND, ncs_pkg::CMD_PING, 10'h000);
		send_item(ncs_pkg::OP_COMMAND, 4'hF, 10'h3FF);
		send_item(ncs_pkg::OP_COMMAND, 4'h4, 10'h000);
		send_item(ncs_pkg::OP_COMMAND, ncs_pkg::REPLY_OFF, 10'h000);
		send_item(ncs_pkg::OP_COMMAND, ncs_pkg::REPLY_ACK, 10'h155);
		send_random(ITEMS_PER_PHASE);
		drain();

		for (int p = 0; p < 6; p++) begin
			if (p == 5)
				write_thresholds(ncs_pkg::THR_W'($urandom_range(0, 1023)),
					ncs_pkg::THR_W'($urandom_range(0, 1023)));
			else
				write_thresholds(his[p], los[p]);
			calm = (p % 3 == 1);
			send_random(ITEMS_PER_PHASE);
			drain();
		end

		if (mismatch_count == 0)
			$display("PASS nibble_command_sensor_slave");
		else
			$display("FAIL nibble_command_sensor_slave");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/ncs_pkg.sv
rtl/ncs_exec.sv
rtl/ncs_reply.sv
rtl/nibble_command_sensor_slave.sv
sim/ncs_reply_checker.sv
sim/tb_nibble_command_sensor_slave.sv
